// File: hw/rtl/vmpg_pkg.sv
// vmpg_pkg: shared types and constants of the vibration motor pattern generator
package vmpg_pkg;

    // request modes
    localparam logic [2:0] MODE_TICK      = 3'd0;
    localparam logic [2:0] MODE_QUEUE     = 3'd1;
    localparam logic [2:0] MODE_DECAY     = 3'd2;
    localparam logic [2:0] MODE_SLIP      = 3'd3;
    localparam logic [2:0] MODE_SLIP_RATE = 3'd4;
    localparam logic [2:0] MODE_SUBMERGED = 3'd5;
    localparam logic [2:0] MODE_CANCEL    = 3'd6;

    // motor commands
    localparam logic [1:0] MOTOR_NONE  = 2'd0;
    localparam logic [1:0] MOTOR_START = 2'd1;
    localparam logic [1:0] MOTOR_STOP  = 2'd2;

    // slot kinds
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_CONST = 2'd1;
    localparam logic [1:0] KIND_MOD   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_STRONG_LEVEL = 2'd0;
    localparam logic [1:0] CFG_ERROR_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_PROBE_PERIOD = 2'd2;
    localparam logic [1:0] CFG_START_FRAMES = 2'd3;

    localparam logic [7:0] RST_STRONG_LEVEL = 8'd70;
    localparam logic [5:0] RST_ERROR_LIMIT  = 6'd30;
    localparam logic [7:0] RST_PROBE_PERIOD = 8'd60;
    localparam logic [3:0] RST_START_FRAMES = 4'd4;

    // density modulation
    localparam logic [15:0] ACCUM_FIRE = 16'h0100;
    localparam logic [15:0] ACCUM_STEP = 16'd4;
    localparam int          CUBE_SHIFT = 9;

    // slip buzz
    localparam logic [2:0] SLIP_ARM       = 3'd7;
    localparam logic [2:0] SLIP_MIN       = 3'd4;
    localparam logic [2:0] SLIP_STEADY    = 3'd5;
    localparam logic [2:0] SLIP_BUZZ_MIN  = 3'd2;
    localparam logic [2:0] BUZZ_SLIP      = 3'd7;
    localparam logic [2:0] BUZZ_SUBMERGED = 3'd4;
    localparam logic [2:0] SLIP_SUBMERGED = 3'd4;
    localparam logic [2:0] RATE_BASE      = 3'd5;
    localparam logic [7:0] RATE_MAX       = 8'd4;

    localparam logic [5:0]  FAIL_MAX    = 6'd63;
    localparam logic [15:0] IDLE_MARGIN = 16'd4;

    // frame remainder unit: 4 bits per step over a 32-bit frame number
    localparam int DIV_BITS_PER_STEP = 4;
    localparam int DIV_STEPS         = 32 / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  level;
        logic [14:0] duration;
        logic        demo_active;
        logic [31:0] frame_number;
        logic        motor_fail;
        logic        pak_detected;
    } req_item_t;

    typedef struct packed {
        logic [1:0] motor_command;
        logic       pak_active;
        logic       idle_and_empty;
        logic [5:0] error_count;
    } rsp_item_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic step;
        logic apply;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_is_tick;
    } dp_status_t;

endpackage

// File: hw/rtl/vmpg_if.sv
// vmpg_if: request and response channel interfaces
interface vmpg_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  level;
    logic [14:0] duration;
    logic        demo_active;
    logic [31:0] frame_number;
    logic        motor_fail;
    logic        pak_detected;

    modport source (
        output valid, mode, level, duration, demo_active, frame_number, motor_fail,
               pak_detected,
        input  ready
    );
    modport sink (
        input  valid, mode, level, duration, demo_active, frame_number, motor_fail,
               pak_detected,
        output ready
    );
endinterface

interface vmpg_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] motor_command;
    logic       pak_active;
    logic       idle_and_empty;
    logic [5:0] error_count;

    modport source (
        output valid, motor_command, pak_active, idle_and_empty, error_count,
        input  ready
    );
    modport sink (
        input  valid, motor_command, pak_active, idle_and_empty, error_count,
        output ready
    );
endinterface

// File: hw/rtl/vmpg_ctrl.sv
// vmpg_ctrl: request sequencing state machine and response valid
module vmpg_ctrl
    import vmpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_APPLY = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.req_is_tick ? ST_LOAD : ST_APPLY;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                cnt_next   = DIV_CNT_W'(DIV_STEPS - 1);
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    cnt_next = cnt_reg - DIV_CNT_W'(1);
                end
            end
            ST_APPLY:
            begin
                // hold here while the previous response is still unread
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_apply_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> (!out_valid_reg || rsp_ready))
        else $error("state applied while response register busy");

    a_load_then_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.step)
        else $error("remainder steps did not follow queue load");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.load, cmd.step, cmd.apply}))
        else $error("more than one datapath command at once");
`endif

endmodule

// File: hw/rtl/vmpg_dp.sv
// vmpg_dp: pulse queue, motor state, cube and frame remainder datapath
module vmpg_dp
    import vmpg_pkg::*;
#(
    parameter int QUEUE_SLOTS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  req_item_t  req_item,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output rsp_item_t  rsp_item
);

    localparam int LAST = QUEUE_SLOTS - 1;

    // configuration
    logic [7:0] strong_level_reg;
    logic [5:0] error_limit_reg;
    logic [7:0] probe_period_reg;
    logic [3:0] start_frames_reg;

    req_item_t item_reg;

    logic [1:0]  slot_kind_reg [QUEUE_SLOTS];
    logic [7:0]  slot_level_reg [QUEUE_SLOTS];
    logic [14:0] slot_duration_reg [QUEUE_SLOTS];
    logic [7:0]  slot_decay_reg [QUEUE_SLOTS];
    logic [1:0]  slot_kind_next [QUEUE_SLOTS];
    logic [7:0]  slot_level_next [QUEUE_SLOTS];
    logic [14:0] slot_duration_next [QUEUE_SLOTS];
    logic [7:0]  slot_decay_next [QUEUE_SLOTS];

    logic [3:0]  start_left_reg, start_left_next;
    logic [14:0] frames_left_reg, frames_left_next;
    logic [7:0]  cur_level_reg, cur_level_next;
    logic [7:0]  cur_decay_reg, cur_decay_next;
    logic [1:0]  cur_kind_reg, cur_kind_next;
    logic [15:0] accum_reg, accum_next;
    logic [2:0]  slip_left_reg, slip_left_next;
    logic [2:0]  buzz_period_reg, buzz_period_next;
    logic        active_reg, active_next;
    logic [5:0]  fail_count_reg, fail_count_next;

    // frame remainder unit
    logic [7:0]  div_reg, div_next;
    logic [7:0]  rem_reg, rem_next;
    logic [31:0] dvd_reg, dvd_next;

    // level cube, two multiplies
    logic [15:0] sq_reg;
    logic [23:0] cube_reg;

    rsp_item_t rsp_reg, rsp_next;

    logic [7:0]  decayed;
    logic [7:0]  probe_div;
    logic        rem_zero;
    logic [8:0]  part;
    logic [1:0]  drive;
    logic [1:0]  motor_cmd;
    logic [5:0]  fail_mid;
    logic [2:0]  slip_armed;
    logic [15:0] busy_frames;
    logic        slots_empty;

    assign status.req_is_tick = (req_item.mode == MODE_TICK);
    assign rsp_item           = rsp_reg;

    assign decayed   = (cur_level_reg > cur_decay_reg) ? cur_level_reg - cur_decay_reg : 8'd0;
    assign probe_div = (probe_period_reg == 8'd0) ? 8'd1 : probe_period_reg;
    assign rem_zero  = (rem_reg == 8'd0);

    // restoring remainder, four dividend bits per step
    always_comb
    begin
        part = {1'b0, rem_reg};
        for (int k = 0; k < DIV_BITS_PER_STEP; k++)
        begin
            part = {part[7:0], dvd_reg[31-k]};
            if (part >= {1'b0, div_reg})
            begin
                part = part - {1'b0, div_reg};
            end
        end
    end

    always_comb
    begin
        slip_armed = (slip_left_reg == 3'd0) ? SLIP_ARM : slip_left_reg;
        if (slip_armed < SLIP_MIN)
        begin
            slip_armed = SLIP_MIN;
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_SLOTS; i++)
        begin
            slot_kind_next[i]     = slot_kind_reg[i];
            slot_level_next[i]    = slot_level_reg[i];
            slot_duration_next[i] = slot_duration_reg[i];
            slot_decay_next[i]    = slot_decay_reg[i];
        end
        start_left_next  = start_left_reg;
        frames_left_next = frames_left_reg;
        cur_level_next   = cur_level_reg;
        cur_decay_next   = cur_decay_reg;
        cur_kind_next    = cur_kind_reg;
        accum_next       = accum_reg;
        slip_left_next   = slip_left_reg;
        buzz_period_next = buzz_period_reg;
        active_next      = active_reg;
        fail_count_next  = fail_count_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        dvd_next         = dvd_reg;
        drive            = MOTOR_NONE;
        motor_cmd        = MOTOR_NONE;
        fail_mid         = fail_count_reg;

        if (cmd.load)
        begin
            if (slot_kind_reg[0] != KIND_EMPTY)
            begin
                accum_next       = '0;
                start_left_next  = start_frames_reg;
                cur_kind_next    = slot_kind_reg[0];
                frames_left_next = slot_duration_reg[0];
                cur_level_next   = slot_level_reg[0];
                cur_decay_next   = slot_decay_reg[0];
            end
            for (int i = 0; i < LAST; i++)
            begin
                slot_kind_next[i]     = slot_kind_reg[i+1];
                slot_level_next[i]    = slot_level_reg[i+1];
                slot_duration_next[i] = slot_duration_reg[i+1];
                slot_decay_next[i]    = slot_decay_reg[i+1];
            end
            slot_kind_next[LAST] = KIND_EMPTY;
            // an active pak needs the buzz phase, an inactive one the probe phase
            div_next = active_reg ? {5'd0, buzz_period_reg} : probe_div;
            rem_next = '0;
            dvd_next = item_reg.frame_number;
        end

        if (cmd.step)
        begin
            rem_next = part[7:0];
            dvd_next = dvd_reg << DIV_BITS_PER_STEP;
        end

        if (cmd.apply)
        begin
            case (item_reg.mode)
                MODE_TICK:
                begin
                    if (start_left_reg != 4'd0)
                    begin
                        start_left_next = start_left_reg - 4'd1;
                        drive           = MOTOR_START;
                    end
                    else if (frames_left_reg != 15'd0)
                    begin
                        frames_left_next = frames_left_reg - 15'd1;
                        cur_level_next   = decayed;
                        if (cur_kind_reg == KIND_CONST)
                        begin
                            drive = MOTOR_START;
                        end
                        else if (accum_reg >= ACCUM_FIRE)
                        begin
                            accum_next = accum_reg - ACCUM_FIRE;
                            drive      = MOTOR_START;
                        end
                        else
                        begin
                            accum_next = accum_reg + {1'b0, cube_reg[23:CUBE_SHIFT]}
                                       + ACCUM_STEP;
                            drive      = MOTOR_STOP;
                        end
                    end
                    else if (slip_left_reg >= SLIP_STEADY)
                    begin
                        drive = MOTOR_START;
                    end
                    else if (slip_left_reg >= SLIP_BUZZ_MIN && buzz_period_reg != 3'd0
                             && rem_zero)
                    begin
                        drive = MOTOR_START;
                    end
                    else
                    begin
                        drive = MOTOR_STOP;
                    end
                    if (slip_left_reg != 3'd0)
                    begin
                        slip_left_next = slip_left_reg - 3'd1;
                    end
                    if (active_reg)
                    begin
                        motor_cmd = drive;
                        if (item_reg.motor_fail)
                        begin
                            fail_mid = (fail_count_reg == FAIL_MAX) ? FAIL_MAX
                                     : fail_count_reg + 6'd1;
                        end
                        else
                        begin
                            fail_mid = '0;
                        end
                    end
                    fail_count_next = fail_mid;
                    if (active_reg)
                    begin
                        if (fail_mid >= error_limit_reg)
                        begin
                            active_next = 1'b0;
                        end
                    end
                    else if (rem_zero)
                    begin
                        active_next     = item_reg.pak_detected;
                        fail_count_next = '0;
                    end
                end
                MODE_QUEUE:
                begin
                    if (!item_reg.demo_active)
                    begin
                        slot_kind_next[LAST] = (item_reg.level > strong_level_reg)
                                             ? KIND_CONST : KIND_MOD;
                        slot_level_next[LAST]    = item_reg.level;
                        slot_duration_next[LAST] = item_reg.duration;
                        slot_decay_next[LAST]    = '0;
                    end
                end
                MODE_DECAY:
                begin
                    slot_decay_next[LAST] = item_reg.level;
                end
                MODE_SLIP:
                begin
                    if (!item_reg.demo_active)
                    begin
                        slip_left_next   = slip_armed;
                        buzz_period_next = BUZZ_SLIP;
                    end
                end
                MODE_SLIP_RATE:
                begin
                    if (!item_reg.demo_active)
                    begin
                        slip_left_next = slip_armed;
                        if (item_reg.level <= RATE_MAX)
                        begin
                            buzz_period_next = RATE_BASE - item_reg.level[2:0];
                        end
                    end
                end
                MODE_SUBMERGED:
                begin
                    if (!item_reg.demo_active)
                    begin
                        slip_left_next   = SLIP_SUBMERGED;
                        buzz_period_next = BUZZ_SUBMERGED;
                    end
                end
                MODE_CANCEL:
                begin
                    active_next = item_reg.pak_detected;
                    motor_cmd   = item_reg.pak_detected ? MOTOR_STOP : MOTOR_NONE;
                    for (int i = 0; i < QUEUE_SLOTS; i++)
                    begin
                        slot_kind_next[i] = KIND_EMPTY;
                    end
                    frames_left_next = '0;
                    slip_left_next   = '0;
                end
                default:
                begin
                    motor_cmd = MOTOR_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        busy_frames = {12'd0, start_left_next} + {1'b0, frames_left_next};
        slots_empty = 1'b1;
        for (int i = 0; i < QUEUE_SLOTS; i++)
        begin
            if (slot_kind_next[i] != KIND_EMPTY)
            begin
                slots_empty = 1'b0;
            end
        end
        rsp_next.motor_command  = motor_cmd;
        rsp_next.pak_active     = active_next;
        rsp_next.idle_and_empty = (busy_frames < IDLE_MARGIN) && slots_empty;
        rsp_next.error_count    = fail_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strong_level_reg <= RST_STRONG_LEVEL;
            error_limit_reg  <= RST_ERROR_LIMIT;
            probe_period_reg <= RST_PROBE_PERIOD;
            start_frames_reg <= RST_START_FRAMES;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_STRONG_LEVEL: strong_level_reg <= cfg_data;
                CFG_ERROR_LIMIT:  error_limit_reg  <= cfg_data[5:0];
                CFG_PROBE_PERIOD: probe_period_reg <= cfg_data;
                CFG_START_FRAMES: start_frames_reg <= cfg_data[3:0];
                default:          strong_level_reg <= strong_level_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                slot_kind_reg[i]     <= KIND_EMPTY;
                slot_level_reg[i]    <= '0;
                slot_duration_reg[i] <= '0;
                slot_decay_reg[i]    <= '0;
            end
            start_left_reg  <= '0;
            frames_left_reg <= '0;
            cur_level_reg   <= '0;
            cur_decay_reg   <= '0;
            cur_kind_reg    <= KIND_EMPTY;
            accum_reg       <= '0;
            slip_left_reg   <= '0;
            buzz_period_reg <= '0;
            active_reg      <= 1'b0;
            fail_count_reg  <= '0;
        end
        else
        begin
            for (int i = 0; i < QUEUE_SLOTS; i++)
            begin
                slot_kind_reg[i]     <= slot_kind_next[i];
                slot_level_reg[i]    <= slot_level_next[i];
                slot_duration_reg[i] <= slot_duration_next[i];
                slot_decay_reg[i]    <= slot_decay_next[i];
            end
            start_left_reg  <= start_left_next;
            frames_left_reg <= frames_left_next;
            cur_level_reg   <= cur_level_next;
            cur_decay_reg   <= cur_decay_next;
            cur_kind_reg    <= cur_kind_next;
            accum_reg       <= accum_next;
            slip_left_reg   <= slip_left_next;
            buzz_period_reg <= buzz_period_next;
            active_reg      <= active_next;
            fail_count_reg  <= fail_count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req_item;
        end
        if (cmd.apply)
        begin
            rsp_reg <= rsp_next;
        end
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        sq_reg   <= 16'(decayed) * 16'(decayed);
        cube_reg <= 24'(sq_reg) * 24'(decayed);
    end

`ifndef SYNTHESIS
    a_fail_clear_on_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && !active_reg && item_reg.mode == MODE_TICK && rem_zero)
        |=> (fail_count_reg == 6'd0))
        else $error("probe did not clear failure count");

    a_inactive_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && !active_reg && item_reg.mode == MODE_TICK)
        |=> (rsp_reg.motor_command == MOTOR_NONE))
        else $error("motor command issued to inactive pak");

    a_cancel_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && item_reg.mode == MODE_CANCEL)
        |=> (slip_left_reg == 3'd0 && frames_left_reg == 15'd0))
        else $error("cancel left pulse or slip running");
`endif

endmodule

// File: hw/rtl/vibration_motor_pattern_generator.sv
// vibration_motor_pattern_generator: top level of the frame-tick motor pattern block
//
// Requests arrive on req (valid/ready); each request gives exactly one response on
// rsp (valid/ready) with the motor command, pak state, idle flag and error count.
// Registers are written through cfg_wr_en/cfg_index/cfg_data; the user must do this
// only while no request is in flight, which the block itself does not enforce;
// writes take effect at once. A tick request (mode 0) first advances the pulse
// queue, then the frame remainder unit retires four bits of the 32-bit frame
// number per cycle (the level cube is formed alongside in two multiplier stages),
// and last the state is updated. Every other request goes straight from acceptance
// to the state update. One request is in work at a time; req is ready again right
// after the response is loaded, so a new request is taken while the previous
// response waits on rsp.
// If rsp stalls, the finished response stays in its output register and the next
// request is held in its final cycle until that register is taken.
// Reset (rst_n, asynchronous, active low) empties the queue, clears all motor
// state, marks the pak inactive and loads the register defaults.
module vibration_motor_pattern_generator
    import vmpg_pkg::*;
#(
    parameter int QUEUE_SLOTS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    vmpg_req_if.sink   req,
    vmpg_rsp_if.source rsp,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    req_item_t  req_item;
    rsp_item_t  rsp_item;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign req_item.mode         = req.mode;
    assign req_item.level        = req.level;
    assign req_item.duration     = req.duration;
    assign req_item.demo_active  = req.demo_active;
    assign req_item.frame_number = req.frame_number;
    assign req_item.motor_fail   = req.motor_fail;
    assign req_item.pak_detected = req.pak_detected;

    assign rsp.motor_command  = rsp_item.motor_command;
    assign rsp.pak_active     = rsp_item.pak_active;
    assign rsp.idle_and_empty = rsp_item.idle_and_empty;
    assign rsp.error_count    = rsp_item.error_count;

    vmpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    vmpg_dp #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_item  (req_item),
        .cmd       (cmd),
        .status    (status),
        .rsp_item  (rsp_item)
    );

endmodule

// File: tb/testbench.sv
// testbench: self-checking random and directed test of vibration_motor_pattern_generator
module testbench;
    import vmpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SLOT_COUNT  = 3;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    vmpg_req_if req_ch();
    vmpg_rsp_if rsp_ch();

    vibration_motor_pattern_generator #(
        .QUEUE_SLOTS(SLOT_COUNT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // request backlog, expected status words, traffic shaping
    req_item_t   req_backlog[$];
    rsp_item_t   expected_status[$];
    logic        req_taken;
    int unsigned send_gap_pct;
    int unsigned rsp_stall_pct;
    int unsigned mismatches;
    logic [31:0] frame_ctr;
    int unsigned fail_burst;

    // pattern generator state
    logic [7:0]  strong_thr;
    logic [5:0]  err_limit;
    logic [7:0]  probe_per;
    logic [3:0]  start_cfg;
    logic [1:0]  slot_kind [SLOT_COUNT];
    logic [7:0]  slot_level [SLOT_COUNT];
    logic [14:0] slot_dur [SLOT_COUNT];
    logic [7:0]  slot_decay [SLOT_COUNT];
    logic [3:0]  start_left;
    logic [14:0] frames_left;
    logic [7:0]  cur_level;
    logic [7:0]  cur_decay;
    logic [1:0]  cur_kind;
    logic [15:0] accum;
    logic [2:0]  slip_left;
    logic [2:0]  buzz_period;
    logic        pak_on;
    logic [5:0]  fault_run;

    function automatic void reset_pattern_state();
        strong_thr  = RST_STRONG_LEVEL;
        err_limit   = RST_ERROR_LIMIT;
        probe_per   = RST_PROBE_PERIOD;
        start_cfg   = RST_START_FRAMES;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_kind[i]  = KIND_EMPTY;
            slot_level[i] = 8'd0;
            slot_dur[i]   = 15'd0;
            slot_decay[i] = 8'd0;
        end
        start_left  = 4'd0;
        frames_left = 15'd0;
        cur_level   = 8'd0;
        cur_decay   = 8'd0;
        cur_kind    = KIND_EMPTY;
        accum       = 16'd0;
        slip_left   = 3'd0;
        buzz_period = 3'd0;
        pak_on      = 1'b0;
        fault_run   = 6'd0;
    endfunction

    function automatic void apply_reg_write(logic [1:0] idx, logic [7:0] val);
        case (idx)
            CFG_STRONG_LEVEL: strong_thr = val;
            CFG_ERROR_LIMIT:  err_limit  = val[5:0];
            CFG_PROBE_PERIOD: probe_per  = val;
            CFG_START_FRAMES: start_cfg  = val[3:0];
            default: ;
        endcase
    endfunction

    // motor access: only an active pak sees the command and counts failures
    function automatic logic [1:0] motor_access(logic [1:0] cmd, logic fail);
        if (!pak_on)
            return MOTOR_NONE;
        if (fail)
        begin
            if (fault_run < 6'd63)
                fault_run = fault_run + 6'd1;
        end
        else
            fault_run = 6'd0;
        return cmd;
    endfunction

    function automatic void shift_slots();
        if (slot_kind[0] != KIND_EMPTY)
        begin
            accum       = 16'd0;
            start_left  = start_cfg;
            cur_kind    = slot_kind[0];
            frames_left = slot_dur[0];
            cur_level   = slot_level[0];
            cur_decay   = slot_decay[0];
        end
        for (int i = 0; i < SLOT_COUNT - 1; i++)
        begin
            slot_kind[i]  = slot_kind[i + 1];
            slot_level[i] = slot_level[i + 1];
            slot_dur[i]   = slot_dur[i + 1];
            slot_decay[i] = slot_decay[i + 1];
        end
        slot_kind[SLOT_COUNT - 1] = KIND_EMPTY;
    endfunction

    function automatic logic [1:0] pulse_frame(logic [31:0] frame, logic fail);
        logic [1:0]  cmd;
        logic [31:0] cube;
        if (start_left != 4'd0)
        begin
            start_left = start_left - 4'd1;
            cmd = motor_access(MOTOR_START, fail);
        end
        else if (frames_left != 15'd0)
        begin
            frames_left = frames_left - 15'd1;
            cur_level = (cur_level > cur_decay) ? cur_level - cur_decay : 8'd0;
            if (cur_kind == KIND_CONST)
                cmd = motor_access(MOTOR_START, fail);
            else if (accum >= 16'h0100)
            begin
                accum = accum - 16'h0100;
                cmd = motor_access(MOTOR_START, fail);
            end
            else
            begin
                cube  = {24'd0, cur_level} * {24'd0, cur_level} * {24'd0, cur_level};
                accum = accum + cube[24:9] + 16'd4;
                cmd = motor_access(MOTOR_STOP, fail);
            end
        end
        else if (slip_left >= 3'd5)
            cmd = motor_access(MOTOR_START, fail);
        else if (slip_left >= 3'd2 && buzz_period != 3'd0
                 && frame % 32'(buzz_period) == 32'd0)
            cmd = motor_access(MOTOR_START, fail);
        else
            cmd = motor_access(MOTOR_STOP, fail);
        if (slip_left != 3'd0)
            slip_left = slip_left - 3'd1;
        return cmd;
    endfunction

    function automatic void arm_slip();
        if (slip_left == 3'd0)
            slip_left = 3'd7;
        if (slip_left < 3'd4)
            slip_left = 3'd4;
    endfunction

    function automatic rsp_item_t motor_frame_step(req_item_t r);
        rsp_item_t  o;
        logic [1:0] cmd;
        logic [7:0] per;
        logic       quiet;
        cmd = MOTOR_NONE;
        case (r.mode)
            MODE_TICK:
            begin
                per = (probe_per == 8'd0) ? 8'd1 : probe_per;
                shift_slots();
                cmd = pulse_frame(r.frame_number, r.motor_fail);
                if (pak_on)
                begin
                    if (fault_run >= err_limit)
                        pak_on = 1'b0;
                end
                else if (r.frame_number % 32'(per) == 32'd0)
                begin
                    pak_on    = r.pak_detected;
                    fault_run = 6'd0;
                end
            end
            MODE_QUEUE:
            begin
                if (!r.demo_active)
                begin
                    slot_kind[SLOT_COUNT - 1]  = (r.level > strong_thr) ? KIND_CONST : KIND_MOD;
                    slot_level[SLOT_COUNT - 1] = r.level;
                    slot_dur[SLOT_COUNT - 1]   = r.duration;
                    slot_decay[SLOT_COUNT - 1] = 8'd0;
                end
            end
            MODE_DECAY:
                slot_decay[SLOT_COUNT - 1] = r.level;
            MODE_SLIP:
            begin
                if (!r.demo_active)
                begin
                    arm_slip();
                    buzz_period = 3'd7;
                end
            end
            MODE_SLIP_RATE:
            begin
                if (!r.demo_active)
                begin
                    arm_slip();
                    if (r.level <= 8'd4)
                        buzz_period = 3'd5 - r.level[2:0];
                end
            end
            MODE_SUBMERGED:
            begin
                if (!r.demo_active)
                begin
                    slip_left   = 3'd4;
                    buzz_period = 3'd4;
                end
            end
            MODE_CANCEL:
            begin
                pak_on = r.pak_detected;
                if (pak_on)
                    cmd = MOTOR_STOP;
                for (int i = 0; i < SLOT_COUNT; i++)
                    slot_kind[i] = KIND_EMPTY;
                frames_left = 15'd0;
                slip_left   = 3'd0;
            end
            default: ;
        endcase
        quiet = (16'(start_left) + 16'(frames_left)) < 16'd4;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot_kind[i] != KIND_EMPTY)
                quiet = 1'b0;
        o.motor_command  = cmd;
        o.pak_active     = pak_on;
        o.idle_and_empty = quiet;
        o.error_count    = fault_run;
        return o;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // monitor: checks responses, tracks register writes, predicts accepted requests
    always @(posedge clk)
    begin
        rsp_item_t got;
        rsp_item_t want;
        req_item_t acc;
        if (!rst_n)
        begin
            reset_pattern_state();
            req_taken <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.motor_command  = rsp_ch.motor_command;
                got.pak_active     = rsp_ch.pak_active;
                got.idle_and_empty = rsp_ch.idle_and_empty;
                got.error_count    = rsp_ch.error_count;
                if (expected_status.size() == 0)
                begin
                    $display("%0t: unexpected response: expected none, actual %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("motor_command", 32'(want.motor_command),
                                32'(got.motor_command));
                    check_field("pak_active", 32'(want.pak_active), 32'(got.pak_active));
                    check_field("idle_and_empty", 32'(want.idle_and_empty),
                                32'(got.idle_and_empty));
                    check_field("error_count", 32'(want.error_count), 32'(got.error_count));
                end
            end
            if (cfg_wr_en)
                apply_reg_write(cfg_index, cfg_data);
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                acc.mode         = req_ch.mode;
                acc.level        = req_ch.level;
                acc.duration     = req_ch.duration;
                acc.demo_active  = req_ch.demo_active;
                acc.frame_number = req_ch.frame_number;
                acc.motor_fail   = req_ch.motor_fail;
                acc.pak_detected = req_ch.pak_detected;
                expected_status.push_back(motor_frame_step(acc));
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        req_item_t nx;
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                nx = req_backlog.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.mode         <= nx.mode;
                req_ch.level        <= nx.level;
                req_ch.duration     <= nx.duration;
                req_ch.demo_active  <= nx.demo_active;
                req_ch.frame_number <= nx.frame_number;
                req_ch.motor_fail   <= nx.motor_fail;
                req_ch.pak_detected <= nx.pak_detected;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // response receiver
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);

    function automatic req_item_t req_of(logic [2:0] mode, logic [7:0] level,
                                         logic [14:0] dur, logic demo, logic [31:0] frame,
                                         logic fail, logic det);
        req_item_t r;
        r.mode         = mode;
        r.level        = level;
        r.duration     = dur;
        r.demo_active  = demo;
        r.frame_number = frame;
        r.motor_fail   = fail;
        r.pak_detected = det;
        return r;
    endfunction

    // mostly frame ticks and pulse requests, with fail bursts and frame jumps
    function automatic req_item_t random_req();
        req_item_t   r;
        int unsigned roll;
        r.level        = 8'($urandom_range(255));
        r.duration     = 15'($urandom_range(32767));
        r.demo_active  = ($urandom_range(99) < 10);
        r.frame_number = $urandom;
        r.motor_fail   = 1'($urandom_range(1));
        r.pak_detected = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < 56)
        begin
            r.mode = MODE_TICK;
            frame_ctr = frame_ctr + 32'd1;
            if ($urandom_range(99) < 2)
                frame_ctr = ($urandom_range(1) != 0) ? $urandom : 32'hFFFF_FFF0;
            r.frame_number = frame_ctr;
            if (fail_burst != 0)
            begin
                fail_burst--;
                r.motor_fail = 1'b1;
            end
            else
            begin
                if ($urandom_range(99) < 3)
                    fail_burst = $urandom_range(70);
                r.motor_fail = ($urandom_range(99) < 8);
            end
            r.pak_detected = ($urandom_range(99) < 85);
        end
        else if (roll < 70)
        begin
            r.mode = MODE_QUEUE;
            if ($urandom_range(99) < 92)
                r.duration = 15'($urandom_range(40));
        end
        else if (roll < 76)
        begin
            r.mode = MODE_DECAY;
            if ($urandom_range(99) < 75)
                r.level = 8'($urandom_range(20));
        end
        else if (roll < 81)
            r.mode = MODE_SLIP;
        else if (roll < 86)
        begin
            r.mode = MODE_SLIP_RATE;
            if ($urandom_range(99) < 80)
                r.level = 8'($urandom_range(6));
        end
        else if (roll < 90)
            r.mode = MODE_SUBMERGED;
        else if (roll < 98)
        begin
            r.mode = MODE_CANCEL;
            r.pak_detected = ($urandom_range(99) < 80);
        end
        else
            r.mode = MODE_UNUSED;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [7:0] thr, input logic [7:0] lim,
                                  input logic [7:0] per, input logic [7:0] strt);
        write_reg(CFG_STRONG_LEVEL, thr);
        write_reg(CFG_ERROR_LIMIT, lim);
        write_reg(CFG_PROBE_PERIOD, per);
        write_reg(CFG_START_FRAMES, strt);
    endtask

    // every request sent and every response taken
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || req_ch.valid || expected_status.size() != 0);
    endtask

    task automatic run_phase(input int n, input int unsigned gap, input int unsigned stall,
                             input bit pause_midway);
        send_gap_pct  = gap;
        rsp_stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if (pause_midway && i == n / 2)
                wait_quiet();
            req_backlog.push_back(random_req());
        end
        wait_quiet();
    endtask

    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_TICK;
        req_ch.level        = 8'd0;
        req_ch.duration     = 15'd0;
        req_ch.demo_active  = 1'b0;
        req_ch.frame_number = 32'd0;
        req_ch.motor_fail   = 1'b0;
        req_ch.pak_detected = 1'b0;
        rsp_ch.ready        = 1'b1;
        cfg_wr_en           = 1'b0;
        cfg_index           = CFG_STRONG_LEVEL;
        cfg_data            = 8'd0;
        send_gap_pct        = 0;
        rsp_stall_pct       = 0;
        mismatches          = 0;
        fail_burst          = 0;
        frame_ctr           = 32'd200;
        rst_n               = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening on reset defaults
        req_backlog.push_back(req_of(MODE_UNUSED, 8'hFF, 15'h7FFF, 1'b1, 32'hFFFF_FFFF,
                                     1'b1, 1'b1));
        req_backlog.push_back(req_of(MODE_TICK, 8'd0, 15'd0, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_TICK, 8'd0, 15'd0, 1'b0, 32'd120, 1'b0, 1'b1));
        req_backlog.push_back(req_of(MODE_QUEUE, 8'd255, 15'd3, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_DECAY, 8'd255, 15'd0, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_TICK, 8'd0, 15'd0, 1'b0, 32'd121, 1'b0, 1'b1));
        req_backlog.push_back(req_of(MODE_QUEUE, 8'd71, 15'd2, 1'b1, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_QUEUE, 8'd70, 15'd6, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_TICK, 8'd0, 15'd0, 1'b0, 32'd122, 1'b1, 1'b1));
        for (int f = 123; f < 128; f++)
            req_backlog.push_back(req_of(MODE_TICK, 8'd0, 15'd0, 1'b0, 32'(f), 1'b0, 1'b1));
        req_backlog.push_back(req_of(MODE_SLIP, 8'd0, 15'd0, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_SLIP_RATE, 8'd0, 15'd0, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_SLIP_RATE, 8'd4, 15'd0, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_SLIP_RATE, 8'd200, 15'd0, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_SUBMERGED, 8'd0, 15'd0, 1'b1, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_SUBMERGED, 8'd0, 15'd0, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_TICK, 8'd0, 15'd0, 1'b0, 32'd128, 1'b0, 1'b1));
        req_backlog.push_back(req_of(MODE_QUEUE, 8'd0, 15'h7FFF, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_CANCEL, 8'd0, 15'd0, 1'b0, 32'd0, 1'b0, 1'b0));
        req_backlog.push_back(req_of(MODE_CANCEL, 8'd0, 15'd0, 1'b0, 32'd0, 1'b0, 1'b1));
        req_backlog.push_back(req_of(MODE_TICK, 8'd0, 15'd0, 1'b0, 32'd129, 1'b0, 1'b1));
        wait_quiet();

        // register extremes and random settings, one idling style per phase
        write_all_regs(8'd0, 8'd1, 8'd1, 8'd0);
        run_phase(178, 0, 0, 1'b0);
        write_all_regs(8'd255, 8'd63, 8'd255, 8'hFF);
        run_phase(178, 72, 0, 1'b0);
        write_all_regs(8'($urandom_range(255)), 8'd0, 8'd0, 8'($urandom_range(15)));
        run_phase(178, 0, 72, 1'b0);
        write_all_regs(8'($urandom_range(255)), 8'($urandom_range(63)),
                       8'($urandom_range(255)), 8'($urandom_range(15)));
        run_phase(178, 10, 10, 1'b0);
        write_all_regs(8'd70, 8'd30, 8'd60, 8'd4);
        run_phase(178, 0, 0, 1'b1);
        write_all_regs(8'($urandom_range(255)), 8'($urandom_range(63)),
                       8'($urandom_range(255)), 8'($urandom_range(15)));
        run_phase(178, 72, 0, 1'b0);
        write_all_regs(8'($urandom_range(255)), 8'($urandom_range(63)),
                       8'($urandom_range(255)), 8'($urandom_range(15)));
        run_phase(178, 0, 72, 1'b0);
        write_all_regs(8'd128, 8'd5, 8'd3, 8'd1);
        run_phase(178, 10, 10, 1'b0);

        repeat (24) @(posedge clk);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("vibration_motor_pattern_generator verification clean");
        else
            $display("vibration_motor_pattern_generator verification failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("vibration_motor_pattern_generator verification failed");
        $finish;
    end

endmodule
